// ===== rtl/core/swmm_pkg.sv =====
`default_nettype none

package swmm_pkg;

    localparam int CFG_W = 7;

    typedef struct packed {
        logic accept;
        logic update;
        logic div_start;
        logic div_step;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic last;
        logic div_done;
    } t_sts;

endpackage

`default_nettype wire

// ===== rtl/core/swmm_if.sv =====
`default_nettype none

interface swmm_in_if #(
    parameter int SAMPLE_BITS = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          last;

    modport source (output valid, output sample, output last, input ready);
    modport sink (input valid, input sample, input last, output ready);
endinterface

interface swmm_out_if #(
    parameter int SUM_W  = 22,
    parameter int MEAN_W = 24
);
    logic                     valid;
    logic                     ready;
    logic signed [SUM_W-1:0]  best_sum;
    logic signed [MEAN_W-1:0] best_mean;
    logic                     too_short;

    modport source (output valid, output best_sum, output best_mean, output too_short,
                    input ready);
    modport sink (input valid, input best_sum, input best_mean, input too_short,
                  output ready);
endinterface

`default_nettype wire

// ===== rtl/core/swmm_ram.sv =====
`default_nettype none

module swmm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/core/swmm_ctrl.sv =====
`default_nettype none

module swmm_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    input  wire logic          i_out_ready,
    input  wire swmm_pkg::t_sts i_sts,
    output swmm_pkg::t_cmd     o_cmd,
    output logic               o_in_ready,
    output logic               o_out_valid
);
    import swmm_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_UPD,
        S_DIV,
        S_OUT
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;

    always_comb begin
        o_cmd           = '0;
        o_cmd.accept    = (r_state == S_IDLE) && i_in_valid;
        o_cmd.update    = (r_state == S_UPD);
        o_cmd.div_start = (r_state == S_UPD) && i_sts.last;
        o_cmd.div_step  = (r_state == S_DIV);
        o_cmd.load_out  = (r_state == S_OUT) && (!r_out_valid || i_out_ready);
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_UPD;
                end
            end
            S_UPD: begin
                n_state = i_sts.last ? S_DIV : S_IDLE;
            end
            S_DIV: begin
                if (i_sts.div_done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

// ===== rtl/core/swmm_dp.sv =====
`default_nettype none

module swmm_dp #(
    parameter int MAX_WINDOW  = 64,
    parameter int SAMPLE_BITS = 16,
    parameter int FRAC_BITS   = 8,
    parameter int SUM_W       = SAMPLE_BITS + $clog2(MAX_WINDOW),
    parameter int MEAN_W      = SAMPLE_BITS + FRAC_BITS
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [swmm_pkg::CFG_W-1:0]      i_cfg_wdata,
    input  wire swmm_pkg::t_cmd                  i_cmd,
    output swmm_pkg::t_sts                       o_sts,
    input  wire logic signed [SAMPLE_BITS-1:0]   i_sample,
    input  wire logic                            i_last,
    output logic signed [SUM_W-1:0]              o_best_sum,
    output logic signed [MEAN_W-1:0]             o_best_mean,
    output logic                                 o_too_short
);
    import swmm_pkg::*;

    localparam int AW    = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int LEN_W = $clog2(MAX_WINDOW + 1);
    localparam int DVD_W = SUM_W + FRAC_BITS;
    localparam int CNT_W = $clog2(DVD_W);

    localparam logic [LEN_W:0]   MaxWin  = (LEN_W + 1)'(MAX_WINDOW);
    localparam logic [AW-1:0]    LastSlt = AW'(MAX_WINDOW - 1);
    localparam logic [CNT_W-1:0] LastCnt = CNT_W'(DVD_W - 1);

    // configuration and sequence state
    logic [CFG_W-1:0]              r_len;
    logic [AW-1:0]                 r_slot;
    logic [LEN_W-1:0]              r_seen;
    logic signed [SUM_W-1:0]       r_sum;
    logic signed [SUM_W-1:0]       r_best;
    logic signed [SAMPLE_BITS-1:0] r_sample;
    logic                          r_last;

    // divider and result
    logic                          r_neg;
    logic [DVD_W-1:0]              r_dvd;
    logic [LEN_W-1:0]              r_rem;
    logic [CNT_W-1:0]              r_cnt;
    logic signed [SUM_W-1:0]       r_res_sum;
    logic                          r_res_short;

    logic [LEN_W-1:0]              w_k;
    logic [LEN_W:0]                w_old_x;
    logic [AW-1:0]                 w_old;
    logic [SAMPLE_BITS-1:0]        w_rdata;
    logic signed [SUM_W:0]         w_acc;
    logic signed [SUM_W-1:0]       n_sum;
    logic signed [SUM_W-1:0]       n_best;
    logic [LEN_W-1:0]              n_seen;
    logic [SUM_W-1:0]              w_mag;
    logic [LEN_W:0]                w_trial;
    logic                          w_qbit;
    logic [DVD_W-1:0]              w_quo;

    always_comb begin
        if (r_len == '0) begin
            w_k = LEN_W'(1);
        end else if (32'(r_len) > 32'(MAX_WINDOW)) begin
            w_k = LEN_W'(MAX_WINDOW);
        end else begin
            w_k = LEN_W'(r_len);
        end
    end

    always_comb begin
        if ({1'b0, (LEN_W)'(r_slot)} >= {1'b0, w_k}) begin
            w_old_x = (LEN_W + 1)'(r_slot) - {1'b0, w_k};
        end else begin
            w_old_x = (LEN_W + 1)'(r_slot) + MaxWin - {1'b0, w_k};
        end
        w_old = w_old_x[AW-1:0];
    end

    swmm_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (MAX_WINDOW),
        .AW    (AW)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (i_cmd.update),
        .i_waddr (r_slot),
        .i_wdata (r_sample),
        .i_raddr (w_old),
        .o_rdata (w_rdata)
    );

    always_comb begin
        n_seen = r_seen;
        n_best = r_best;
        if (r_seen >= w_k) begin
            w_acc = (SUM_W + 1)'(r_sum) + (SUM_W + 1)'(r_sample)
                  - (SUM_W + 1)'($signed(w_rdata));
            n_sum = w_acc[SUM_W-1:0];
            if (n_sum > r_best) begin
                n_best = n_sum;
            end
        end else begin
            w_acc  = (SUM_W + 1)'(r_sum) + (SUM_W + 1)'(r_sample);
            n_sum  = w_acc[SUM_W-1:0];
            n_seen = r_seen + LEN_W'(1);
            if (n_seen == w_k) begin
                n_best = n_sum;
            end
        end
        w_mag = n_best[SUM_W-1] ? SUM_W'(-n_best) : n_best;
    end

    // restoring divide, one quotient bit per cycle
    always_comb begin
        w_trial = {r_rem, r_dvd[DVD_W-1]};
        w_qbit  = (w_trial >= {1'b0, w_k});
        w_quo   = r_neg ? DVD_W'(~r_dvd + DVD_W'(1)) : r_dvd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len  <= CFG_W'(1);
            r_slot <= '0;
            r_seen <= '0;
            r_sum  <= '0;
            r_best <= '0;
        end else if (i_cfg_we) begin
            r_len  <= i_cfg_wdata;
            r_slot <= '0;
            r_seen <= '0;
            r_sum  <= '0;
            r_best <= '0;
        end else if (i_cmd.update) begin
            if (r_last) begin
                r_slot <= '0;
                r_seen <= '0;
                r_sum  <= '0;
                r_best <= '0;
            end else begin
                r_slot <= (r_slot == LastSlt) ? '0 : r_slot + AW'(1);
                r_seen <= n_seen;
                r_sum  <= n_sum;
                r_best <= n_best;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_sample <= i_sample;
            r_last   <= i_last;
        end
        if (i_cmd.div_start) begin
            r_neg       <= n_best[SUM_W-1];
            r_dvd       <= DVD_W'(w_mag) << FRAC_BITS;
            r_rem       <= '0;
            r_cnt       <= '0;
            r_res_sum   <= n_best;
            r_res_short <= (n_seen < w_k);
        end else if (i_cmd.div_step) begin
            r_dvd <= {r_dvd[DVD_W-2:0], w_qbit};
            r_rem <= w_qbit ? LEN_W'(w_trial - {1'b0, w_k}) : w_trial[LEN_W-1:0];
            r_cnt <= r_cnt + CNT_W'(1);
        end
        if (i_cmd.load_out) begin
            o_too_short <= r_res_short;
            o_best_sum  <= r_res_short ? '0 : r_res_sum;
            o_best_mean <= r_res_short ? '0 : w_quo[MEAN_W-1:0];
        end
    end

    assign o_sts.last     = r_last;
    assign o_sts.div_done = (r_cnt == LastCnt);

endmodule

`default_nettype wire

// ===== rtl/core/sliding_window_max_mean_core.sv =====
// Sliding-window maximum sum and mean.
// i_in carries signed samples; last marks the end of a sequence. o_out carries one
// word per sequence: the largest sum over any window of window_len consecutive
// samples, that sum * 2^FRAC_BITS / window_len (truncated toward zero), and
// too_short when the sequence never filled a window (sums then read zero).
// i_cfg_we/i_cfg_wdata write window_len (0 acts as 1, above MAX_WINDOW clamps)
// and restart the sequence; write only while the block is idle.
// Each sample is accepted in S_IDLE, where the oldest sample is read from the
// ring RAM, and updates the running sum in S_UPD; no new sample is taken until
// the block is back in S_IDLE. A last sample then goes through bit-serial
// division of the SUM_W + FRAC_BITS bit dividend (30 bits at defaults) in S_DIV,
// and S_OUT loads the output register, which raises o_out.valid.
// While a result waits on o_out, new samples are still taken; only the next
// result load waits for the receiver.
// Reset (synchronous, active low) sets window_len to 1 and clears the sequence.
// The ring RAM needs no clearing: a slot's data is used only after it is written.
`default_nettype none

module sliding_window_max_mean_core #(
    parameter int MAX_WINDOW  = 64,
    parameter int SAMPLE_BITS = 16,
    parameter int FRAC_BITS   = 8
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_we,
    input  wire logic [swmm_pkg::CFG_W-1:0]  i_cfg_wdata,
    swmm_in_if.sink                          i_in,
    swmm_out_if.source                       o_out
);
    import swmm_pkg::*;

    localparam int SUM_W  = SAMPLE_BITS + $clog2(MAX_WINDOW);
    localparam int MEAN_W = SAMPLE_BITS + FRAC_BITS;

    t_cmd w_cmd;
    t_sts w_sts;

    swmm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_out_ready (o_out.ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid)
    );

    swmm_dp #(
        .MAX_WINDOW  (MAX_WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS),
        .FRAC_BITS   (FRAC_BITS),
        .SUM_W       (SUM_W),
        .MEAN_W      (MEAN_W)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_sample    (i_in.sample),
        .i_last      (i_in.last),
        .o_best_sum  (o_out.best_sum),
        .o_best_mean (o_out.best_mean),
        .o_too_short (o_out.too_short)
    );

`ifndef NO_ASSERTIONS
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("input taken twice in a row");

    a_one_command: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({w_cmd.accept, w_cmd.update, w_cmd.div_step, w_cmd.load_out}))
        else $error("conflicting datapath commands");

    a_short_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.too_short) |-> (o_out.best_sum == '0 && o_out.best_mean == '0))
        else $error("short sequence word carries nonzero sums");

    a_load_after_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.div_start |=> !o_out.valid || $stable(o_out.best_sum))
        else $error("result word changed while divide started");
`endif

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
`default_nettype none

module tb_top;

    localparam int LEN_CAP     = 64;
    localparam int DRAIN_WAIT  = 48;
    localparam int HOLD_CYCLES = 400;
    localparam int RANDOM_END  = 770;
    localparam int CALM_FROM   = 680;

    typedef struct packed {
        logic signed [21:0] sum;
        logic signed [23:0] mean;
        logic               short_seq;
    } t_result;

    typedef struct packed {
        logic                  is_cfg;
        logic [6:0]            cfg;
        logic signed [15:0]    smp;
        logic                  lst;
        logic                  typed;
        t_result               want;
    } t_step;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n;
    logic                         i_cfg_we;
    logic [swmm_pkg::CFG_W-1:0]   i_cfg_wdata;

    swmm_in_if  #(.SAMPLE_BITS(16))        in_if ();
    swmm_out_if #(.SUM_W(22), .MEAN_W(24)) out_if ();

    sliding_window_max_mean_core #(
        .MAX_WINDOW  (64),
        .SAMPLE_BITS (16),
        .FRAC_BITS   (8)
    ) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (in_if),
        .o_out       (out_if)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // window tracker state
    logic signed [15:0] ring [LEN_CAP];
    logic [5:0]         wr_slot;
    int unsigned        seen;
    longint             run_sum;
    longint             best_sum;
    logic [6:0]         win_reg;

    t_result owed_words[$];
    int      err_count;
    int      sample_count;
    int      seq_count;
    int      word_count;
    int      short_count;
    int      setting_count;
    bit      calm;
    bit      hold_req;

    t_step dir_steps [27] = '{
        '{1'b0, 7'd0,   16'sd32767,  1'b1, 1'b1, '{22'sd32767,  24'sd8388352,  1'b0}},
        '{1'b0, 7'd0,  -16'sd32768,  1'b1, 1'b1, '{-22'sd32768, -24'sd8388608, 1'b0}},
        '{1'b0, 7'd0,   16'sd0,      1'b1, 1'b1, '{22'sd0,      24'sd0,        1'b0}},
        '{1'b1, 7'd0,   16'sd0,      1'b0, 1'b0, '0},
        '{1'b0, 7'd0,   16'sd5,      1'b0, 1'b0, '0},
        '{1'b0, 7'd0,   16'sd7,      1'b1, 1'b1, '{22'sd7,      24'sd1792,     1'b0}},
        '{1'b1, 7'd3,   16'sd0,      1'b0, 1'b0, '0},
        '{1'b0, 7'd0,   16'sd100,    1'b1, 1'b1, '{22'sd0,      24'sd0,        1'b1}},
        '{1'b0, 7'd0,   16'sd1,      1'b0, 1'b0, '0},
        '{1'b0, 7'd0,   16'sd2,      1'b0, 1'b0, '0},
        '{1'b1, 7'd2,   16'sd0,      1'b0, 1'b0, '0},
        '{1'b0, 7'd0,   16'sd10,     1'b0, 1'b0, '0},
        '{1'b0, 7'd0,   16'sd20,     1'b1, 1'b1, '{22'sd30,     24'sd3840,     1'b0}},
        '{1'b1, 7'd127, 16'sd0,      1'b0, 1'b0, '0},
        '{1'b0, 7'd0,   16'sd32767,  1'b0, 1'b0, '0},
        '{1'b0, 7'd0,  -16'sd32768,  1'b1, 1'b1, '{22'sd0,      24'sd0,        1'b1}},
        '{1'b1, 7'd3,   16'sd0,      1'b0, 1'b0, '0},
        '{1'b0, 7'd0,  -16'sd32768,  1'b0, 1'b0, '0},
        '{1'b0, 7'd0,  -16'sd32768,  1'b0, 1'b0, '0},
        '{1'b0, 7'd0,  -16'sd32768,  1'b1, 1'b1, '{-22'sd98304, -24'sd8388608, 1'b0}},
        '{1'b0, 7'd0,  -16'sd1,      1'b0, 1'b0, '0},
        '{1'b0, 7'd0,   16'sd0,      1'b0, 1'b0, '0},
        '{1'b0, 7'd0,   16'sd0,      1'b1, 1'b0, '0},
        '{1'b1, 7'd2,   16'sd0,      1'b0, 1'b0, '0},
        '{1'b0, 7'd0,  -16'sd3,      1'b0, 1'b0, '0},
        '{1'b0, 7'd0,   16'sd4,      1'b0, 1'b0, '0},
        '{1'b0, 7'd0,  -16'sd1,      1'b1, 1'b0, '0}
    };

    function automatic int unsigned eff_window();
        if (win_reg == 7'd0) begin
            return 1;
        end
        if (win_reg > 7'(LEN_CAP)) begin
            return LEN_CAP;
        end
        return win_reg;
    endfunction

    task automatic clear_sequence();
        wr_slot  = '0;
        seen     = 0;
        run_sum  = 0;
        best_sum = 0;
    endtask

    task automatic track_sample(input logic signed [15:0] smp, input logic lst,
                                output bit made, output t_result r);
        int unsigned k;
        logic [5:0]  old;
        longint      mean_full;
        k = eff_window();
        r = '0;
        if (seen >= k) begin
            old = wr_slot - 6'(k);
            run_sum += longint'(smp) - longint'(ring[old]);
            if (run_sum > best_sum) begin
                best_sum = run_sum;
            end
        end else begin
            run_sum += longint'(smp);
            seen++;
            if (seen == k) begin
                best_sum = run_sum;
            end
        end
        ring[wr_slot] = smp;
        wr_slot++;
        made = lst;
        if (lst) begin
            if (seen < k) begin
                r.short_seq = 1'b1;
            end else begin
                mean_full = (best_sum * 256) / longint'(k);
                r.sum  = best_sum[21:0];
                r.mean = mean_full[23:0];
            end
            clear_sequence();
        end
    endtask

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("MISMATCH t=%0t %s: got %0d want %0d", $time, what, got, want);
        err_count++;
    endtask

    function automatic logic signed [15:0] pick_sample();
        logic signed [15:0] v;
        case ($urandom_range(0, 7))
            0: v = 16'sh7fff;
            1: v = 16'sh8000;
            2: v = 16'(int'($urandom_range(0, 20)) - 10);
            default: v = 16'($urandom);
        endcase
        return v;
    endfunction

    // called at a falling edge, returns at a falling edge with valid still high
    task automatic send_sample(input logic signed [15:0] smp, input logic lst,
                               input logic typed, input t_result want);
        bit      made;
        t_result pred;
        if (!calm && $urandom_range(0, 3) == 0) begin
            in_if.valid = 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge i_clk);
        end
        in_if.valid  = 1'b1;
        in_if.sample = smp;
        in_if.last   = lst;
        do @(posedge i_clk); while (!in_if.ready);
        track_sample(smp, lst, made, pred);
        if (made) begin
            owed_words.push_back(typed ? want : pred);
            seq_count++;
        end
        sample_count++;
        @(negedge i_clk);
    endtask

    task automatic wait_idle();
        in_if.valid = 1'b0;
        wait (owed_words.size() == 0);
        repeat (DRAIN_WAIT) @(negedge i_clk);
    endtask

    task automatic set_window(input int unsigned v);
        wait_idle();
        i_cfg_we    = 1'b1;
        i_cfg_wdata = 7'(v);
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
        win_reg     = 7'(v);
        clear_sequence();
        setting_count++;
    endtask

    // output side: random stalls plus one long hold-off on request
    initial begin
        out_if.ready = 1'b0;
        forever begin
            if (hold_req) begin
                hold_req     = 1'b0;
                out_if.ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                out_if.ready = 1'b0;
                repeat ($urandom_range(1, 8)) @(negedge i_clk);
            end else begin
                out_if.ready = 1'b1;
                @(negedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        t_result w;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            word_count++;
            if (out_if.too_short) begin
                short_count++;
            end
            if (owed_words.size() == 0) begin
                report_mismatch("unexpected word, best_sum", out_if.best_sum, 0);
            end else begin
                w = owed_words.pop_front();
                if (out_if.best_sum !== w.sum) begin
                    report_mismatch("best_sum", out_if.best_sum, w.sum);
                end
                if (out_if.best_mean !== w.mean) begin
                    report_mismatch("best_mean", out_if.best_mean, w.mean);
                end
                if (out_if.too_short !== w.short_seq) begin
                    report_mismatch("too_short", out_if.too_short, w.short_seq);
                end
            end
        end
    end

    initial begin
        #6_000_000;
        $display("sliding_window_max_mean_core verification failed");
        $finish;
    end

    initial begin
        int unsigned wl;
        int unsigned k;
        int unsigned nseq;
        int unsigned len;
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_wdata   = '0;
        in_if.valid   = 1'b0;
        in_if.sample  = '0;
        in_if.last    = 1'b0;
        err_count     = 0;
        sample_count  = 0;
        seq_count     = 0;
        word_count    = 0;
        short_count   = 0;
        setting_count = 0;
        calm          = 1'b0;
        hold_req      = 1'b0;
        win_reg       = 7'd1;
        clear_sequence();
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        foreach (dir_steps[i]) begin
            if (dir_steps[i].is_cfg) begin
                set_window(dir_steps[i].cfg);
            end else begin
                send_sample(dir_steps[i].smp, dir_steps[i].lst, dir_steps[i].typed,
                            dir_steps[i].want);
            end
        end

        // back-pressure: one-sample sequences pile up behind a stalled output
        set_window(1);
        hold_req = 1'b1;
        repeat (40) send_sample(pick_sample(), 1'b1, 1'b0, '0);

        while (sample_count < RANDOM_END) begin
            calm = (sample_count >= CALM_FROM);
            case ($urandom_range(0, 9))
                0: wl = 0;
                1: wl = 64;
                2: wl = $urandom_range(65, 127);
                3: wl = $urandom_range(9, 63);
                default: wl = $urandom_range(1, 8);
            endcase
            set_window(wl);
            k    = eff_window();
            nseq = (k > 16) ? $urandom_range(1, 2) : $urandom_range(2, 6);
            repeat (nseq) begin
                if (k > 1 && $urandom_range(0, 4) == 0) begin
                    len = $urandom_range(1, k - 1);
                end else begin
                    len = $urandom_range(k, k + 12);
                end
                for (int unsigned j = 1; j <= len; j++) begin
                    send_sample(pick_sample(), j == len, 1'b0, '0);
                end
            end
            // unfinished sequence, dropped by the next window write
            if ($urandom_range(0, 3) == 0) begin
                repeat ($urandom_range(1, k + 3)) send_sample(pick_sample(), 1'b0, 1'b0, '0);
            end
        end

        wait_idle();
        $display("run covered %0d samples in %0d sequences over %0d window settings",
                 sample_count, seq_count, setting_count);
        $display("%0d words checked, %0d flagged too short", word_count, short_count);
        if (err_count == 0 && owed_words.size() == 0) begin
            $display("sliding_window_max_mean_core verification clean");
        end else begin
            $display("sliding_window_max_mean_core verification failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== files.f =====
rtl/core/swmm_pkg.sv
rtl/core/swmm_if.sv
rtl/core/swmm_ram.sv
rtl/core/swmm_ctrl.sv
rtl/core/swmm_dp.sv
rtl/core/sliding_window_max_mean_core.sv
tb/tb_top.sv
